@@ sv/swdt_pkg.sv @@
// Shared types and constants of the single-wire dimming transmitter.
package swdt_pkg;

  // Command codes carried by an input item.
  typedef enum logic [2:0] {
    CMD_TICK    = 3'd0,
    CMD_WRITE   = 3'd1,
    CMD_BLANK   = 3'd2,
    CMD_UNBLANK = 3'd3,
    CMD_DETECT  = 3'd4
  } cmd_t;

  // Configuration register indexes.
  localparam logic [2:0] REG_ACK_ENABLE   = 3'd0;
  localparam logic [2:0] REG_DEVICE_ADDR  = 3'd1;
  localparam logic [2:0] REG_SHORT_TICKS  = 3'd2;
  localparam logic [2:0] REG_LONG_TICKS   = 3'd3;
  localparam logic [2:0] REG_GAP_TICKS    = 3'd4;
  localparam logic [2:0] REG_DDELAY_TICKS = 3'd5;
  localparam logic [2:0] REG_DETECT_TICKS = 3'd6;
  localparam logic [2:0] REG_RESET_TICKS  = 3'd7;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Frame layout: address byte then data byte, sent MSB first.
  localparam int FRAME_BITS = 16;
  localparam int BIT_IDX_W  = 5;
  localparam int LEVEL_W    = 5;
  localparam int TICK_W     = 16;

  // Reset values of the configuration registers.
  localparam logic [7:0]  RST_DEVICE_ADDR  = 8'd88;
  localparam logic [7:0]  RST_SHORT_TICKS  = 8'd4;
  localparam logic [7:0]  RST_LONG_TICKS   = 8'd9;
  localparam logic [7:0]  RST_GAP_TICKS    = 8'd4;
  localparam logic [15:0] RST_DDELAY_TICKS = 16'd100;
  localparam logic [15:0] RST_DETECT_TICKS = 16'd450;
  localparam logic [15:0] RST_RESET_TICKS  = 16'd4000;
  localparam logic [4:0]  RST_LAST_LEVEL   = 5'd31;

  // Current configuration as seen by the sequencer.
  typedef struct packed {
    logic        ack_enable;
    logic [7:0]  device_address;
    logic [7:0]  short_ticks;
    logic [7:0]  long_ticks;
    logic [7:0]  gap_ticks;
    logic [15:0] detect_delay_ticks;
    logic [15:0] detect_ticks;
    logic [15:0] reset_ticks;
  } cfg_t;

  // One input item.
  typedef struct packed {
    logic [2:0]         command;
    logic [LEVEL_W-1:0] brightness;
    logic               line_sample;
  } item_t;

  // One result item.
  typedef struct packed {
    logic rejected;
    logic no_ack;
    logic busy_res;
    logic line_level;
    logic drive_enable;
  } result_t;

endpackage

@@ sv/swdt_cfg_regs.sv @@
// Configuration register file of the single-wire dimming transmitter.
module swdt_cfg_regs import swdt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wen,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode the register index and update the addressed field.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wen) begin
      unique case (cfg_index)
        REG_ACK_ENABLE:   cfg_nxt.ack_enable         = cfg_wdata[0];
        REG_DEVICE_ADDR:  cfg_nxt.device_address     = cfg_wdata[7:0];
        REG_SHORT_TICKS:  cfg_nxt.short_ticks        = cfg_wdata[7:0];
        REG_LONG_TICKS:   cfg_nxt.long_ticks         = cfg_wdata[7:0];
        REG_GAP_TICKS:    cfg_nxt.gap_ticks          = cfg_wdata[7:0];
        REG_DDELAY_TICKS: cfg_nxt.detect_delay_ticks = cfg_wdata;
        REG_DETECT_TICKS: cfg_nxt.detect_ticks       = cfg_wdata;
        REG_RESET_TICKS:  cfg_nxt.reset_ticks        = cfg_wdata;
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ack_enable         <= 1'b0;
      cfg_r.device_address     <= RST_DEVICE_ADDR;
      cfg_r.short_ticks        <= RST_SHORT_TICKS;
      cfg_r.long_ticks         <= RST_LONG_TICKS;
      cfg_r.gap_ticks          <= RST_GAP_TICKS;
      cfg_r.detect_delay_ticks <= RST_DDELAY_TICKS;
      cfg_r.detect_ticks       <= RST_DETECT_TICKS;
      cfg_r.reset_ticks        <= RST_RESET_TICKS;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ sv/swdt_core.sv @@
// Wire sequencer: detect sequence, frame bits, acknowledge window, one tick per item.
module swdt_core import swdt_pkg::*; #(
  parameter int unsigned ACK_WINDOW = 900
) (
  input  logic    clk,
  input  logic    rst_n,
  input  cfg_t    cfg,
  input  logic    advance,
  input  item_t   item,
  output result_t result
);

  typedef enum logic [3:0] {
    PH_IDLE  = 4'd0,
    PH_RST   = 4'd1,
    PH_DDLY  = 4'd2,
    PH_DWIN  = 4'd3,
    PH_START = 4'd4,
    PH_BLO   = 4'd5,
    PH_BHI   = 4'd6,
    PH_EOS   = 4'd7,
    PH_END   = 4'd8,
    PH_ACK   = 4'd9
  } phase_t;

  localparam logic [TICK_W-1:0] ACK_TICKS = TICK_W'(ACK_WINDOW);
  localparam logic [BIT_IDX_W-1:0] LAST_BIT = BIT_IDX_W'(FRAME_BITS);
  localparam logic [BIT_IDX_W-1:0] HALF_BIT = BIT_IDX_W'(FRAME_BITS / 2);
  localparam logic [3:0] TOP_BIT = 4'(FRAME_BITS - 1);

  phase_t                 phase_r, phase_nxt;
  logic [TICK_W-1:0]      tick_r, tick_nxt;
  logic [BIT_IDX_W-1:0]   bit_r, bit_nxt;
  logic [FRAME_BITS-1:0]  frame_r, frame_nxt;
  logic [LEVEL_W-1:0]     level_r, level_nxt;
  logic                   blanked_r, blanked_nxt;
  logic                   resend_r, resend_nxt;
  logic                   ack_seen_r, ack_seen_nxt;

  logic [TICK_W-1:0]      dur;
  logic [TICK_W-1:0]      raw_dur;
  logic                   cur_bit;
  logic                   is_op;
  result_t                res;

  // Zero durations act as one tick.
  function automatic logic [TICK_W-1:0] dur_of(input logic [TICK_W-1:0] v);
    dur_of = (v == '0) ? TICK_W'(1) : v;
  endfunction

  function automatic logic [FRAME_BITS-1:0] build_frame(input logic [7:0] addr,
                                                        input logic ack,
                                                        input logic [LEVEL_W-1:0] lvl);
    build_frame = {addr, ack, 2'b00, lvl};
  endfunction

  // One tick of the sequencer for the item at the head of the pipeline.
  always_comb begin
    phase_nxt    = phase_r;
    tick_nxt     = tick_r;
    bit_nxt      = bit_r;
    frame_nxt    = frame_r;
    level_nxt    = level_r;
    blanked_nxt  = blanked_r;
    resend_nxt   = resend_r;
    ack_seen_nxt = ack_seen_r;
    res          = '0;
    res.drive_enable = 1'b1;
    res.line_level   = 1'b1;
    raw_dur      = TICK_W'(1);
    cur_bit      = 1'b0;

    // Commands are taken only while idle.
    is_op = (item.command == CMD_WRITE) || (item.command == CMD_BLANK) ||
            (item.command == CMD_UNBLANK) || (item.command == CMD_DETECT);
    if (is_op) begin
      if (phase_r != PH_IDLE) begin
        res.rejected = 1'b1;
      end else begin
        unique case (item.command)
          CMD_WRITE: begin
            if (blanked_r) begin
              level_nxt = item.brightness;
            end else begin
              frame_nxt = build_frame(cfg.device_address, cfg.ack_enable, item.brightness);
              bit_nxt   = '0;
              phase_nxt = PH_START;
              tick_nxt  = '0;
            end
          end
          CMD_BLANK: blanked_nxt = 1'b1;
          CMD_UNBLANK: begin
            frame_nxt = build_frame(cfg.device_address, cfg.ack_enable, level_r);
            bit_nxt   = '0;
            tick_nxt  = '0;
            if (blanked_r) begin
              blanked_nxt = 1'b0;
              resend_nxt  = 1'b1;
              phase_nxt   = PH_RST;
            end else begin
              phase_nxt   = PH_START;
            end
          end
          CMD_DETECT: begin
            resend_nxt = 1'b0;
            phase_nxt  = PH_RST;
            tick_nxt   = '0;
          end
          default: phase_nxt = phase_r;
        endcase
      end
    end

    res.busy_res = (phase_nxt != PH_IDLE);
    cur_bit = frame_nxt[TOP_BIT - bit_nxt[3:0]];

    // Wire level and duration of the current phase.
    unique case (phase_nxt)
      PH_RST:   begin res.line_level = 1'b0; raw_dur = cfg.reset_ticks; end
      PH_DDLY:  begin res.line_level = 1'b1; raw_dur = cfg.detect_delay_ticks; end
      PH_DWIN:  begin res.line_level = 1'b0; raw_dur = cfg.detect_ticks; end
      PH_START: begin res.line_level = 1'b1; raw_dur = TICK_W'(cfg.gap_ticks); end
      PH_BLO: begin
        res.line_level = 1'b0;
        raw_dur = TICK_W'(cur_bit ? cfg.short_ticks : cfg.long_ticks);
      end
      PH_BHI: begin
        res.line_level = 1'b1;
        raw_dur = TICK_W'(cur_bit ? cfg.long_ticks : cfg.short_ticks);
      end
      PH_EOS:   begin res.line_level = 1'b0; raw_dur = TICK_W'(cfg.gap_ticks); end
      PH_END:   begin res.line_level = 1'b0; raw_dur = TICK_W'(cfg.gap_ticks); end
      PH_ACK: begin
        res.drive_enable = 1'b0;
        res.line_level   = 1'b0;
        raw_dur          = ACK_TICKS;
        if (!item.line_sample) begin
          ack_seen_nxt = 1'b1;
        end
      end
      default: begin
        phase_nxt      = PH_IDLE;
        res.line_level = !blanked_nxt;
      end
    endcase
    dur = dur_of(raw_dur);

    // Count the tick and move to the next phase when the duration is reached.
    if (phase_nxt != PH_IDLE) begin
      tick_nxt = tick_nxt + TICK_W'(1);
      if (tick_nxt >= dur) begin
        tick_nxt = '0;
        unique case (phase_nxt)
          PH_RST:   phase_nxt = PH_DDLY;
          PH_DDLY:  phase_nxt = PH_DWIN;
          PH_DWIN: begin
            phase_nxt  = resend_nxt ? PH_START : PH_IDLE;
            if (resend_nxt) begin
              bit_nxt = '0;
            end
            resend_nxt = 1'b0;
          end
          PH_START: phase_nxt = PH_BLO;
          PH_BLO:   phase_nxt = PH_BHI;
          PH_BHI: begin
            bit_nxt = bit_nxt + BIT_IDX_W'(1);
            if (bit_nxt >= LAST_BIT) begin
              phase_nxt = PH_END;
            end else if (bit_nxt == HALF_BIT) begin
              phase_nxt = PH_EOS;
            end else begin
              phase_nxt = PH_BLO;
            end
          end
          PH_EOS:   phase_nxt = PH_START;
          PH_END: begin
            level_nxt = frame_nxt[LEVEL_W-1:0];
            if (frame_nxt[7]) begin
              ack_seen_nxt = 1'b0;
              phase_nxt    = PH_ACK;
            end else begin
              phase_nxt    = PH_IDLE;
            end
          end
          default: begin
            if (ack_seen_nxt) begin
              phase_nxt = PH_IDLE;
            end else begin
              res.no_ack = 1'b1;
              resend_nxt = 1'b0;
              phase_nxt  = PH_RST;
            end
            ack_seen_nxt = 1'b0;
          end
        endcase
      end
    end
  end

  // Sequencer state advances once per item handed to the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      tick_r     <= '0;
      bit_r      <= '0;
      frame_r    <= '0;
      level_r    <= RST_LAST_LEVEL;
      blanked_r  <= 1'b0;
      resend_r   <= 1'b0;
      ack_seen_r <= 1'b0;
    end else if (advance) begin
      phase_r    <= phase_nxt;
      tick_r     <= tick_nxt;
      bit_r      <= bit_nxt;
      frame_r    <= frame_nxt;
      level_r    <= level_nxt;
      blanked_r  <= blanked_nxt;
      resend_r   <= resend_nxt;
      ack_seen_r <= ack_seen_nxt;
    end
  end

  assign result = res;

  // A missed acknowledge always restarts the detect sequence.
  a_noack_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && res.no_ack) |=> (phase_r == PH_RST))
    else $error("no_ack without restart of detect sequence");

  // Rejection only happens while a sequence is running.
  a_reject_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && res.rejected) |-> (phase_r != PH_IDLE))
    else $error("command rejected while idle");

  // The wire is released only inside the acknowledge window.
  a_release_ack: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && !res.drive_enable) |-> (phase_r == PH_ACK))
    else $error("wire released outside acknowledge window");

  // Bit index never passes the frame length.
  a_bit_range: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |-> (bit_r <= LAST_BIT))
    else $error("bit index beyond frame");

endmodule

@@ sv/single_wire_dimming_transmitter_unit.sv @@
// Top level of the single-wire dimming transmitter: stream ports, item register, result register.
//
// Each input item is one tick of the wire timing, carrying a command (tick, write
// brightness, blank, unblank, detect) and the sampled wire level. Every item yields
// exactly one result item with the drive enable, the driven level, busy, a no-ack
// pulse and a rejected pulse. The block takes one item per clock cycle while the result channel
// keeps up; an accepted item waits in the input register until the result register is empty or
// being emptied, and that register then loads the result of one pass through the
// sequencer's next-state logic, which updates the whole sequencer state once per
// item. Write, blank, unblank and detect commands are ignored and flagged as rejected
// while a sequence or frame is running; unused command codes act as a plain tick. All
// timing is counted in items, so the wire durations scale with the item rate.
module single_wire_dimming_transmitter_unit import swdt_pkg::*; #(
  parameter int unsigned ACK_WINDOW = 900
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input channel
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [4:0] brightness, [5] line_sample, [7:6] zero
  input  logic [2:0]            in_tuser,   // [2:0] command
  // Result channel
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [7:0]            out_tdata,  // [0] drive_enable, [1] line_level,
                                            // [2] busy_res, [3] no_ack, [4] rejected,
                                            // [7:5] zero
  // Configuration port
  input  logic                  cfg_wen,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t    cfg;
  item_t   item_r;
  item_t   item_nxt;
  logic    item_valid_r;
  logic    out_valid_r;
  result_t out_r;
  result_t res;
  logic    advance;
  logic    accept;

  swdt_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  swdt_core #(
    .ACK_WINDOW (ACK_WINDOW)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .advance (advance),
    .item    (item_r),
    .result  (res)
  );

  // The item moves on when the result register is empty or being emptied.
  assign advance   = item_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !item_valid_r || advance;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    item_nxt.command     = in_tuser;
    item_nxt.brightness  = in_tdata[LEVEL_W-1:0];
    item_nxt.line_sample = in_tdata[LEVEL_W];
  end

  // Input register stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (accept) begin
      item_valid_r <= 1'b1;
    end else if (advance) begin
      item_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= item_nxt;
    end
  end

  // Result register stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_r};

  // An empty result register never holds back the input register.
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    (item_valid_r && !out_valid_r) |-> advance)
    else $error("item stalled with empty result register");

endmodule

@@ verif/single_wire_dimming_transmitter_unit_tb.sv @@
// Self-checking stream testbench for the single-wire dimming transmitter top level.
module single_wire_dimming_transmitter_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import swdt_pkg::*;

  localparam int ACK_WINDOW_TICKS = 900;
  localparam int WATCHDOG_LIMIT   = 4000;
  localparam int HOLD_CYCLES      = 400;
  localparam int IDLE_PCT         = 18;
  localparam int CHUNK_TICKS      = 16;

  // Sequencer phases of the wire protocol, as tracked by the predictor.
  typedef enum logic [3:0] {
    PH_IDLE, PH_RST, PH_DDLY, PH_DWIN, PH_START, PH_BLO, PH_BHI, PH_EOS, PH_END, PH_ACK
  } wire_phase_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata = '0;   // [4:0] brightness, [5] line_sample, [7:6] zero
  logic [2:0]            in_tuser = '0;   // [2:0] command
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [7:0]            out_tdata;       // [0] drive_enable, [1] line_level, [2] busy_res,
                                          // [3] no_ack, [4] rejected, [7:5] zero
  logic                  cfg_wen = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Predicted sequencer state and configuration.
  wire_phase_t        sq_phase = PH_IDLE;
  logic [15:0]        sq_count = '0;
  logic [4:0]         sq_bit = '0;
  logic [15:0]        sq_frame = '0;
  logic [LEVEL_W-1:0] sq_level = RST_LAST_LEVEL;
  logic               sq_blanked = 1'b0;
  logic               sq_resend = 1'b0;
  logic               sq_acked = 1'b0;
  cfg_t               sq_cfg = '{ack_enable: 1'b0, device_address: RST_DEVICE_ADDR,
                                 short_ticks: RST_SHORT_TICKS, long_ticks: RST_LONG_TICKS,
                                 gap_ticks: RST_GAP_TICKS, detect_delay_ticks: RST_DDELAY_TICKS,
                                 detect_ticks: RST_DETECT_TICKS, reset_ticks: RST_RESET_TICKS};

  item_t   pending_items[$];
  result_t due_results[$];
  item_t   drv_item;
  int      pushed_n = 0;
  int      taken_n = 0;
  int      results_n = 0;
  int      errs = 0;
  int      low_permil = 500;
  int      quiet = 0;
  int      hold_left = 0;
  int      holds_done = 0;
  logic    hold_req = 1'b0;
  logic    calm;

  single_wire_dimming_transmitter_unit #(.ACK_WINDOW(ACK_WINDOW_TICKS)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #6 clk = ~clk;

  // No idling on either side during one long stretch of the run.
  assign calm = (taken_n >= 100) && (taken_n < 250);

  // A duration register holding zero counts as one tick.
  function automatic logic [15:0] at_least_one(logic [15:0] v);
    return (v == 16'd0) ? 16'd1 : v;
  endfunction

  function automatic void move_to(wire_phase_t p);
    sq_phase = p;
    sq_count = '0;
  endfunction

  // Address byte, then ack-request bit over the brightness.
  function automatic void load_frame(logic [LEVEL_W-1:0] level);
    sq_frame = {sq_cfg.device_address, sq_cfg.ack_enable, 2'b00, level};
    sq_bit = '0;
  endfunction

  // Advance the predicted sequencer by one tick and return the wire result it gives.
  function automatic result_t wire_step(item_t it);
    logic [15:0] span;
    logic        drv, lvl, busy, noack, rej, cur;
    drv = 1'b1;
    lvl = 1'b1;
    noack = 1'b0;
    rej = 1'b0;
    span = 16'd1;

    // Commands are taken only while idle; codes above detect act as a tick.
    if (it.command >= CMD_WRITE && it.command <= CMD_DETECT) begin
      if (sq_phase != PH_IDLE) begin
        rej = 1'b1;
      end else begin
        case (it.command)
          CMD_WRITE: begin
            if (sq_blanked) begin
              sq_level = it.brightness;
            end else begin
              load_frame(it.brightness);
              move_to(PH_START);
            end
          end
          CMD_BLANK: sq_blanked = 1'b1;
          CMD_UNBLANK: begin
            load_frame(sq_level);
            if (sq_blanked) begin
              sq_blanked = 1'b0;
              sq_resend = 1'b1;
              move_to(PH_RST);
            end else begin
              move_to(PH_START);
            end
          end
          default: begin
            sq_resend = 1'b0;
            move_to(PH_RST);
          end
        endcase
      end
    end

    busy = (sq_phase != PH_IDLE);
    cur = sq_frame[4'd15 - sq_bit[3:0]];

    // Level and duration of the current phase.
    case (sq_phase)
      PH_RST: begin
        lvl = 1'b0;
        span = at_least_one(sq_cfg.reset_ticks);
      end
      PH_DDLY: span = at_least_one(sq_cfg.detect_delay_ticks);
      PH_DWIN: begin
        lvl = 1'b0;
        span = at_least_one(sq_cfg.detect_ticks);
      end
      PH_START: span = at_least_one({8'd0, sq_cfg.gap_ticks});
      PH_BLO: begin
        lvl = 1'b0;
        span = at_least_one({8'd0, cur ? sq_cfg.short_ticks : sq_cfg.long_ticks});
      end
      PH_BHI: span = at_least_one({8'd0, cur ? sq_cfg.long_ticks : sq_cfg.short_ticks});
      PH_EOS, PH_END: begin
        lvl = 1'b0;
        span = at_least_one({8'd0, sq_cfg.gap_ticks});
      end
      PH_ACK: begin
        drv = 1'b0;
        lvl = 1'b0;
        span = at_least_one(16'(ACK_WINDOW_TICKS));
        if (!it.line_sample) sq_acked = 1'b1;
      end
      default: lvl = !sq_blanked;
    endcase

    // Count the tick and move on when the phase has run its length.
    if (sq_phase != PH_IDLE) begin
      sq_count = sq_count + 16'd1;
      if (sq_count >= span) begin
        case (sq_phase)
          PH_RST: move_to(PH_DDLY);
          PH_DDLY: move_to(PH_DWIN);
          PH_DWIN: begin
            if (sq_resend) begin
              move_to(PH_START);
              sq_bit = '0;
            end else begin
              move_to(PH_IDLE);
            end
            sq_resend = 1'b0;
          end
          PH_START: move_to(PH_BLO);
          PH_BLO: move_to(PH_BHI);
          PH_BHI: begin
            sq_bit = sq_bit + 5'd1;
            if (sq_bit >= FRAME_BITS) move_to(PH_END);
            else if (sq_bit == FRAME_BITS / 2) move_to(PH_EOS);
            else move_to(PH_BLO);
          end
          PH_EOS: move_to(PH_START);
          PH_END: begin
            sq_level = sq_frame[4:0];
            if (sq_frame[7]) begin
              sq_acked = 1'b0;
              move_to(PH_ACK);
            end else begin
              move_to(PH_IDLE);
            end
          end
          default: begin
            if (sq_acked) begin
              move_to(PH_IDLE);
            end else begin
              noack = 1'b1;
              sq_resend = 1'b0;
              move_to(PH_RST);
            end
            sq_acked = 1'b0;
          end
        endcase
      end
    end

    return '{rejected: rej, no_ack: noack, busy_res: busy, line_level: lvl,
             drive_enable: drv};
  endfunction

  // Driver: offers pending items and predicts each one as it is accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        due_results.push_back(wire_step(drv_item));
        taken_n++;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_items.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
          drv_item = pending_items.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {2'b00, drv_item.line_sample, drv_item.brightness};
          in_tuser <= drv_item.command;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result item and drives the receiver's ready.
  always @(posedge clk) begin
    result_t got, want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_n++;
        got = result_t'(out_tdata[4:0]);
        if (due_results.size() == 0) begin
          $error("result item with no expectation waiting: %h", out_tdata);
          errs++;
        end else begin
          want = due_results.pop_front();
          if (got.drive_enable !== want.drive_enable) begin
            $error("drive_enable: expected %0d, actual %0d", want.drive_enable,
                   got.drive_enable);
            errs++;
          end
          if (got.line_level !== want.line_level) begin
            $error("line_level: expected %0d, actual %0d", want.line_level, got.line_level);
            errs++;
          end
          if (got.busy_res !== want.busy_res) begin
            $error("busy_res: expected %0d, actual %0d", want.busy_res, got.busy_res);
            errs++;
          end
          if (got.no_ack !== want.no_ack) begin
            $error("no_ack: expected %0d, actual %0d", want.no_ack, got.no_ack);
            errs++;
          end
          if (got.rejected !== want.rejected) begin
            $error("rejected: expected %0d, actual %0d", want.rejected, got.rejected);
            errs++;
          end
        end
      end

      // Long hold-off while the sender still has items queued, once in the run.
      if (hold_left != 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (hold_req && holds_done == 0 && pending_items.size() >= 8) begin
        hold_left = HOLD_CYCLES;
        holds_done++;
        out_tready <= 1'b0;
      end else begin
        out_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // Watchdog on cycles without any accepted item, taken result or register write.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wen) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic logic pick_sample();
    return ($urandom_range(0, 999) < low_permil) ? 1'b0 : 1'b1;
  endfunction

  task automatic offer(logic [2:0] cmd, logic [LEVEL_W-1:0] bright, logic sample);
    item_t it;
    it.command = cmd;
    it.brightness = bright;
    it.line_sample = sample;
    pending_items.push_back(it);
    pushed_n++;
  endtask

  // Plain ticks, with a few unused command codes mixed in.
  task automatic offer_ticks(int n);
    logic [2:0] cmd;
    for (int i = 0; i < n; i++) begin
      cmd = ($urandom_range(0, 9) == 0) ? CMD_DETECT + 3'($urandom_range(1, 3)) : CMD_TICK;
      offer(cmd, 5'($urandom_range(0, 31)), pick_sample());
    end
  endtask

  task automatic settle();
    while (taken_n != pushed_n) @(posedge clk);
  endtask

  task automatic run_to_idle();
    settle();
    while (sq_phase != PH_IDLE) begin
      offer_ticks(CHUNK_TICKS);
      settle();
    end
  endtask

  // Sequencer idle, every result back, and the pipeline given time to empty.
  task automatic quiesce();
    run_to_idle();
    while (due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_ACK_ENABLE:   sq_cfg.ack_enable = val[0];
      REG_DEVICE_ADDR:  sq_cfg.device_address = val[7:0];
      REG_SHORT_TICKS:  sq_cfg.short_ticks = val[7:0];
      REG_LONG_TICKS:   sq_cfg.long_ticks = val[7:0];
      REG_GAP_TICKS:    sq_cfg.gap_ticks = val[7:0];
      REG_DDELAY_TICKS: sq_cfg.detect_delay_ticks = val;
      REG_DETECT_TICKS: sq_cfg.detect_ticks = val;
      default:          sq_cfg.reset_ticks = val;
    endcase
  endtask

  task automatic apply_cfg(logic ack, logic [7:0] addr, logic [7:0] sh, logic [7:0] lg,
                           logic [7:0] gp, logic [15:0] dd, logic [15:0] dt, logic [15:0] rt);
    quiesce();
    set_reg(REG_ACK_ENABLE, {15'd0, ack});
    set_reg(REG_DEVICE_ADDR, {8'd0, addr});
    set_reg(REG_SHORT_TICKS, {8'd0, sh});
    set_reg(REG_LONG_TICKS, {8'd0, lg});
    set_reg(REG_GAP_TICKS, {8'd0, gp});
    set_reg(REG_DDELAY_TICKS, dd);
    set_reg(REG_DETECT_TICKS, dt);
    set_reg(REG_RESET_TICKS, rt);
    @(posedge clk);
    cfg_wen <= 1'b0;
  endtask

  // Short durations, now and then zero.
  function automatic int small_ticks(int hi);
    return ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, hi);
  endfunction

  // Stimulus: directed cases, random phases, then an acknowledge window.
  initial begin
    int pick;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings while idle: field extremes, unused codes, blank and a stored write.
    offer(CMD_TICK, 5'd31, 1'b1);
    offer(CMD_TICK, 5'd0, 1'b0);
    offer(CMD_DETECT + 3'd3, 5'd21, 1'b1);
    offer(CMD_DETECT + 3'd1, 5'd10, 1'b0);
    offer(CMD_BLANK, 5'd0, 1'b0);
    offer(CMD_BLANK, 5'd31, 1'b1);
    offer(CMD_WRITE, 5'd17, 1'b1);
    offer(CMD_TICK, 5'd0, 1'b1);
    offer(CMD_DETECT + 3'd2, 5'd0, 1'b0);

    // Short timing with the reset address and gap: unblank runs detect, then the frame.
    quiesce();
    set_reg(REG_SHORT_TICKS, 16'd1);
    set_reg(REG_LONG_TICKS, 16'd2);
    set_reg(REG_DDELAY_TICKS, 16'd2);
    set_reg(REG_DETECT_TICKS, 16'd3);
    set_reg(REG_RESET_TICKS, 16'd2);
    @(posedge clk);
    cfg_wen <= 1'b0;
    offer(CMD_UNBLANK, 5'd0, 1'b1);
    offer(CMD_WRITE, 5'd5, 1'b1);
    offer(CMD_BLANK, 5'd0, 1'b0);
    offer(CMD_UNBLANK, 5'd0, 1'b1);
    offer(CMD_DETECT, 5'd0, 1'b1);
    offer_ticks(24);
    hold_req = 1'b1;
    run_to_idle();

    // Every duration register at zero: resend without detect, detect alone, blank cycle.
    apply_cfg(1'b0, 8'h00, 8'd0, 8'd0, 8'd0, 16'd0, 16'd0, 16'd0);
    offer(CMD_UNBLANK, 5'd9, 1'b0);
    run_to_idle();
    offer(CMD_DETECT, 5'd0, 1'b1);
    run_to_idle();
    offer(CMD_BLANK, 5'd0, 1'b1);
    offer(CMD_WRITE, 5'd9, 1'b1);
    offer(CMD_UNBLANK, 5'd0, 1'b1);
    run_to_idle();

    // Random phases: commands landing anywhere in a sequence.
    for (int p = 0; p < 2; p++) begin
      apply_cfg(1'b0, 8'($urandom_range(0, 255)),
                8'(small_ticks(2)), 8'(small_ticks(2)), 8'(small_ticks(2)),
                16'(small_ticks(3)), 16'(small_ticks(3)), 16'(small_ticks(3)));
      for (int n = 0; n < 6; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 45) offer(CMD_WRITE, 5'($urandom_range(0, 31)), pick_sample());
        else if (pick < 60) offer(CMD_BLANK, 5'($urandom_range(0, 31)), pick_sample());
        else if (pick < 80) offer(CMD_UNBLANK, 5'($urandom_range(0, 31)), pick_sample());
        else if (pick < 90) offer(CMD_DETECT, 5'($urandom_range(0, 31)), pick_sample());
        else offer_ticks($urandom_range(1, 4));
        offer_ticks($urandom_range(0, 6));
      end
      run_to_idle();
    end

    // Acknowledge requested: the wire is released and commands are refused in the window.
    apply_cfg(1'b1, 8'hFF, 8'd0, 8'd0, 8'd0, 16'd0, 16'd0, 16'd0);
    low_permil = 300;
    offer(CMD_WRITE, 5'd31, 1'b1);
    offer_ticks(30);
    offer(CMD_BLANK, 5'd0, 1'b0);
    offer(CMD_WRITE, 5'd1, 1'b1);
    offer_ticks(20);

    settle();
    while (due_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errs == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ single_wire_dimming_transmitter_unit.f @@
sv/swdt_pkg.sv
sv/swdt_cfg_regs.sv
sv/swdt_core.sv
sv/single_wire_dimming_transmitter_unit.sv
verif/single_wire_dimming_transmitter_unit_tb.sv
